// ===== src/stl_pkg.sv =====
`timescale 1ns / 1ps
package stl_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM, M_STR, M_ESC, M_GT, M_LT, M_MINUS, M_LPAR,
        M_CMT, M_CSTAR, M_CPAREN, M_HALT
    } t_mode;

    // Sequencer phases: take a request, match keywords, emit a run.
    typedef enum logic [2:0] {
        S_IN, S_KW, S_RUN, S_OUT
    } t_seq;

    localparam logic [5:0] K_IDENT  = 6'd23;
    localparam logic [5:0] K_NUM    = 6'd24;
    localparam logic [5:0] K_STR    = 6'd25;
    localparam logic [5:0] K_EQ     = 6'd26;
    localparam logic [5:0] K_GE     = 6'd27;
    localparam logic [5:0] K_GT     = 6'd28;
    localparam logic [5:0] K_LE     = 6'd29;
    localparam logic [5:0] K_GETS   = 6'd30;
    localparam logic [5:0] K_LT     = 6'd31;
    localparam logic [5:0] K_NE     = 6'd32;
    localparam logic [5:0] K_TO     = 6'd33;
    localparam logic [5:0] K_MINUS  = 6'd34;
    localparam logic [5:0] K_PLUS   = 6'd35;
    localparam logic [5:0] K_DIV    = 6'd36;
    localparam logic [5:0] K_MUL    = 6'd37;
    localparam logic [5:0] K_AMP    = 6'd38;
    localparam logic [5:0] K_LBRACK = 6'd39;
    localparam logic [5:0] K_RBRACK = 6'd40;
    localparam logic [5:0] K_COMMA  = 6'd41;
    localparam logic [5:0] K_LPAR   = 6'd42;
    localparam logic [5:0] K_RPAR   = 6'd43;
    localparam logic [5:0] K_SEMI   = 6'd44;
    localparam logic [5:0] K_END    = 6'd45;
    localparam logic [5:0] K_ERR    = 6'd46;

    localparam logic [3:0] E_NONE    = 4'd0;
    localparam logic [3:0] E_ILLEGAL = 4'd1;
    localparam logic [3:0] E_NUMBIG  = 4'd2;
    localparam logic [3:0] E_IDLONG  = 4'd3;
    localparam logic [3:0] E_ESCAPE  = 4'd4;
    localparam logic [3:0] E_NONPRT  = 4'd5;
    localparam logic [3:0] E_STROPEN = 4'd6;
    localparam logic [3:0] E_CMTOPEN = 4'd7;
    localparam logic [3:0] E_NEST    = 4'd8;

    localparam int KW_COUNT = 23;
    localparam int KW_MAXLEN = 7;

    // Keyword text, first char in the low byte, zero padded.
    function automatic logic [55:0] kw_text(input logic [4:0] k);
        unique case (k)
            5'd0:  kw_text = 56'h646e61;
            5'd1:  kw_text = 56'h7961727261;
            5'd2:  kw_text = 56'h6e69676562;
            5'd3:  kw_text = 56'h6e61656c6f6f62;
            5'd4:  kw_text = 56'h6c6c696863;
            5'd5:  kw_text = 56'h656e69666564;
            5'd6:  kw_text = 56'h6f64;
            5'd7:  kw_text = 56'h65736c65;
            5'd8:  kw_text = 56'h6669736c65;
            5'd9:  kw_text = 56'h646e65;
            5'd10: kw_text = 56'h74697865;
            5'd11: kw_text = 56'h65736c6166;
            5'd12: kw_text = 56'h6669;
            5'd13: kw_text = 56'h72656765746e69;
            5'd14: kw_text = 56'h646f6d;
            5'd15: kw_text = 56'h746f6e;
            5'd16: kw_text = 56'h726f;
            5'd17: kw_text = 56'h6d6172676f7270;
            5'd18: kw_text = 56'h64616572;
            5'd19: kw_text = 56'h6e656874;
            5'd20: kw_text = 56'h65757274;
            5'd21: kw_text = 56'h656c696877;
            5'd22: kw_text = 56'h6574697277;
            default: kw_text = '0;
        endcase
    endfunction

    function automatic logic [2:0] kw_len(input logic [4:0] k);
        unique case (k)
            5'd0, 5'd9, 5'd14, 5'd15: kw_len = 3'd3;
            5'd6, 5'd12, 5'd16: kw_len = 3'd2;
            5'd7, 5'd10, 5'd18, 5'd19, 5'd20: kw_len = 3'd4;
            5'd5: kw_len = 3'd6;
            5'd3, 5'd13, 5'd17: kw_len = 3'd7;
            default: kw_len = 3'd5;
        endcase
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

// ===== src/stl_kwmatch.sv =====
`timescale 1ns / 1ps
// Compare the held identifier against one keyword per cycle, while the lexer's output is not stalled.
module stl_kwmatch
    import stl_pkg::*;
(
    input  logic [4:0]  i_kw_idx,
    input  logic [5:0]  i_len,
    input  logic [55:0] i_text,
    output logic        o_hit
);
    logic [55:0] w_kw;
    logic [2:0]  w_n;

    always_comb begin
        w_kw  = kw_text(i_kw_idx);
        w_n   = kw_len(i_kw_idx);
        o_hit = (i_len == {3'd0, w_n}) && (i_text == w_kw);
    end
endmodule

// ===== src/source_text_lexer.sv =====
`timescale 1ns / 1ps
// Every result is held in the output register before it is shown.
// A byte that ends a number or operator is re-handled after the flush; an escape gives two results.
// Identifier end: a search of the 23 keywords, one keyword a cycle while the output is free;
// if none matches, each character is read and then emitted; the ending byte is then re-handled.
// Input not ready while a result is stalled, in a search or run, or while r_redo or r_esc2 is set.
// Reset (i_rst_n low, synchronous) returns to idle, line 1 column 0; halts after errors.
module source_text_lexer
    import stl_pkg::*;
#(
    parameter int MAX_IDENT_LEN    = 32,
    parameter int MAX_COMMENT_NEST = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_token_kind,
    output logic [30:0] o_number_value,
    output logic [7:0]  o_text_char,
    output logic        o_text_valid,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_column,
    output logic [3:0]  o_error_code,
    output logic        o_last
);
    localparam int IW = $clog2(MAX_IDENT_LEN + 1);
    localparam int AW = (MAX_IDENT_LEN > 1) ? $clog2(MAX_IDENT_LEN) : 1;

    // Queued work after the current byte: pending steps in order.
    // After flushing a number/ident/op the byte itself is re-handled.
    t_seq  r_seq, n_seq;
    t_mode r_mode, n_mode;
    logic [IW-1:0] r_len, n_len;
    logic [30:0] r_num, n_num;
    logic [4:0]  r_depth, n_depth;
    logic [15:0] r_line, n_line, r_col, n_col, r_sl, n_sl, r_sc, n_sc;
    logic        r_nl, n_nl;
    logic [7:0]  r_c, n_c;
    logic        r_endm, n_endm;     // byte request was an end mark
    logic        r_redo, n_redo;     // re-handle r_c after the run
    logic        r_esc2, n_esc2;     // second escape result pending
    logic [4:0]  r_kw, n_kw;
    logic [IW-1:0] r_ri, n_ri;
    logic [55:0] r_kwtext;           // first chars of identifier
    logic [7:0]  r_buf [MAX_IDENT_LEN];
    logic [7:0]  r_rd;
    logic        w_we;
    logic [AW-1:0] w_wa, w_ra;

    // output register
    logic        r_ov, n_ov;
    logic [5:0]  r_tk, n_tk;
    logic [30:0] r_nv, n_nv;
    logic [7:0]  r_tc, n_tc;
    logic        r_tv, n_tv;
    logic [15:0] r_tl, n_tl, r_tcol, n_tcol;
    logic [3:0]  r_ec, n_ec;
    logic        r_ol, n_ol;

    logic w_hit, w_free, w_acc;
    logic [34:0] w_mul;

    stl_kwmatch u_kw (
        .i_kw_idx (r_kw),
        .i_len    (6'(r_len)),
        .i_text   (r_kwtext),
        .o_hit    (w_hit)
    );

    assign w_free  = !r_ov || i_ready;
    assign o_ready = (r_seq == S_IN) && w_free && !r_redo && !r_esc2;
    assign w_acc   = i_valid && o_ready;
    assign w_ra    = r_ri[AW-1:0];

    // Identifier store
    always_ff @(posedge i_clk) begin
        if (w_we) r_buf[w_wa] <= n_c;
        r_rd <= r_buf[w_ra];
    end

    // Keep the first characters zero padded for the keyword compare
    always_ff @(posedge i_clk) begin
        if (w_we && w_wa == '0) r_kwtext <= {48'd0, n_c};
        else if (w_we && int'(w_wa) < KW_MAXLEN) r_kwtext[w_wa*8 +: 8] <= n_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= S_IN; r_mode <= M_IDLE; r_len <= '0; r_num <= '0; r_depth <= '0;
            r_line <= 16'd1; r_col <= '0; r_sl <= 16'd1; r_sc <= '0; r_nl <= 1'b0;
            r_redo <= 1'b0; r_esc2 <= 1'b0; r_endm <= 1'b0; r_kw <= '0; r_ri <= '0;
            r_ov <= 1'b0; r_c <= '0;
        end else begin
            r_seq <= n_seq; r_mode <= n_mode; r_len <= n_len; r_num <= n_num;
            r_depth <= n_depth; r_line <= n_line; r_col <= n_col; r_sl <= n_sl;
            r_sc <= n_sc; r_nl <= n_nl; r_redo <= n_redo; r_esc2 <= n_esc2;
            r_endm <= n_endm; r_kw <= n_kw; r_ri <= n_ri; r_ov <= n_ov; r_c <= n_c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tk <= n_tk; r_nv <= n_nv; r_tc <= n_tc; r_tv <= n_tv;
        r_tl <= n_tl; r_tcol <= n_tcol; r_ec <= n_ec; r_ol <= n_ol;
    end

    // Sequencer: each cycle at most one result and one step of work.
    always_comb begin
        logic       emit;
        logic [7:0] c;
        logic       endm;
        logic       proc;
        logic       restart;
        emit = 1'b0; c = r_c; endm = r_endm; proc = 1'b0; restart = 1'b0;
        n_seq = r_seq; n_mode = r_mode; n_len = r_len; n_num = r_num; n_depth = r_depth;
        n_line = r_line; n_col = r_col; n_sl = r_sl; n_sc = r_sc; n_nl = r_nl;
        n_c = r_c; n_endm = r_endm; n_redo = r_redo; n_esc2 = r_esc2; n_kw = r_kw;
        n_ri = r_ri; w_we = 1'b0; w_wa = r_len[AW-1:0];
        w_mul = '0;
        n_ov = r_ov && !i_ready;
        n_tk = r_tk; n_nv = r_nv; n_tc = r_tc; n_tv = r_tv; n_tl = r_tl;
        n_tcol = r_tcol; n_ec = r_ec; n_ol = r_ol;

        if (w_free) begin
            n_tk = K_END; n_nv = '0; n_tc = '0; n_tv = 1'b0; n_tl = r_sl; n_tcol = r_sc;
            n_ec = E_NONE; n_ol = 1'b1;
            unique case (r_seq)
                S_IN: begin
                    if (r_esc2) begin
                        emit = 1'b1; n_tk = K_STR; n_tc = r_c; n_tv = 1'b1; n_ol = 1'b0;
                        n_esc2 = 1'b0;
                    end else if (r_redo) begin
                        proc = 1'b1; n_redo = 1'b0;
                    end else if (w_acc) begin
                        c = i_char_code; endm = i_kind; n_c = c; n_endm = endm;
                        if (endm) proc = 1'b1;
                        else if (r_mode != M_HALT) begin
                            proc = 1'b1;
                            if (r_nl) begin
                                if (r_line != 16'hffff) n_line = r_line + 16'd1;
                                n_col = '0;
                            end
                            if (n_col != 16'hffff) n_col = n_col + 16'd1;
                            n_nl = (c == 8'd10);
                        end
                    end
                end
                S_KW: begin
                    if (w_hit) begin
                        emit = 1'b1; n_tk = {1'b0, r_kw}; restart = 1'b1;
                        n_seq = S_IN;
                    end else if (r_kw == 5'(KW_COUNT - 1)) begin
                        n_seq = S_RUN; n_ri = '0;
                    end else n_kw = r_kw + 5'd1;
                end
                S_RUN: begin
                    n_ri = r_ri + IW'(1); n_seq = S_OUT;
                end
                default: begin
                    emit = 1'b1; n_tk = K_IDENT; n_tc = r_rd; n_tv = 1'b1;
                    n_ol = (r_ri == r_len);
                    if (r_ri == r_len) begin
                        restart = 1'b1; n_seq = S_IN;
                    end else n_seq = S_RUN;
                end
            endcase

            // After an identifier: finish end mark or re-handle the byte
            if (restart) begin
                n_mode = M_IDLE;
                if (r_endm) n_redo = 1'b1;
                else n_redo = 1'b1;
            end

            if (proc) begin
                if (endm) begin
                    unique case (r_mode)
                        M_HALT: ;
                        M_IDENT: begin
                            n_seq = S_KW; n_kw = '0;
                        end
                        M_STR, M_ESC: begin
                            emit = 1'b1; n_tk = K_ERR; n_ec = E_STROPEN; n_mode = M_HALT;
                        end
                        M_CMT, M_CSTAR, M_CPAREN: begin
                            emit = 1'b1; n_tk = K_ERR; n_ec = E_CMTOPEN; n_mode = M_HALT;
                        end
                        M_NUM: begin
                            emit = 1'b1; n_tk = K_NUM; n_nv = r_num; n_mode = M_IDLE;
                            n_redo = 1'b1;
                        end
                        M_GT, M_LT, M_MINUS, M_LPAR: begin
                            emit = 1'b1; n_mode = M_IDLE; n_redo = 1'b1;
                            n_tk = (r_mode == M_GT) ? K_GT : (r_mode == M_LT) ? K_LT :
                                   (r_mode == M_MINUS) ? K_MINUS : K_LPAR;
                        end
                        default: begin
                            emit = 1'b1; n_tk = K_END; n_tl = n_line; n_tcol = n_col;
                        end
                    endcase
                end else begin
                    logic start;
                    start = 1'b0;
                    unique case (r_mode)
                        M_IDLE: start = 1'b1;
                        M_IDENT: begin
                            if (is_alpha(c) || is_digit(c)) begin
                                if (r_len >= IW'(MAX_IDENT_LEN)) begin
                                    emit = 1'b1; n_tk = K_ERR; n_ec = E_IDLONG;
                                    n_mode = M_HALT;
                                end else begin
                                    w_we = 1'b1; n_len = r_len + IW'(1);
                                end
                            end else begin
                                n_seq = S_KW; n_kw = '0;
                            end
                        end
                        M_NUM: begin
                            if (is_digit(c)) begin
                                w_mul = {4'd0, r_num} * 35'd10 + {27'd0, c - 8'h30};
                                if (w_mul > 35'h7fffffff) begin
                                    emit = 1'b1; n_tk = K_ERR; n_ec = E_NUMBIG;
                                    n_mode = M_HALT;
                                end else n_num = w_mul[30:0];
                            end else begin
                                emit = 1'b1; n_tk = K_NUM; n_nv = r_num; n_mode = M_IDLE;
                                n_redo = 1'b1;
                            end
                        end
                        M_STR: begin
                            if (c == 8'h22) begin
                                emit = 1'b1; n_tk = K_STR; n_mode = M_IDLE;
                            end else if (c == 8'h5c) n_mode = M_ESC;
                            else if (c >= 8'h20 && c <= 8'h7e) begin
                                emit = 1'b1; n_tk = K_STR; n_tc = c; n_tv = 1'b1;
                                n_ol = 1'b0;
                            end else begin
                                emit = 1'b1; n_tk = K_ERR; n_ec = E_NONPRT;
                                n_tl = n_line; n_tcol = n_col; n_mode = M_HALT;
                            end
                        end
                        M_ESC: begin
                            if (c == 8'h6e || c == 8'h74 || c == 8'h22 || c == 8'h5c) begin
                                emit = 1'b1; n_tk = K_STR; n_tc = 8'h5c; n_tv = 1'b1;
                                n_ol = 1'b0; n_esc2 = 1'b1; n_mode = M_STR;
                            end else begin
                                emit = 1'b1; n_tk = K_ERR; n_ec = E_ESCAPE;
                                n_tl = n_line; n_tcol = n_col; n_mode = M_HALT;
                            end
                        end
                        M_GT: begin
                            emit = 1'b1; n_mode = M_IDLE;
                            if (c == 8'h3d) n_tk = K_GE;
                            else begin n_tk = K_GT; n_redo = 1'b1; end
                        end
                        M_LT: begin
                            emit = 1'b1; n_mode = M_IDLE;
                            if (c == 8'h3d) n_tk = K_LE;
                            else if (c == 8'h2d) n_tk = K_GETS;
                            else begin n_tk = K_LT; n_redo = 1'b1; end
                        end
                        M_MINUS: begin
                            emit = 1'b1; n_mode = M_IDLE;
                            if (c == 8'h3e) n_tk = K_TO;
                            else begin n_tk = K_MINUS; n_redo = 1'b1; end
                        end
                        M_LPAR: begin
                            if (c == 8'h2a) begin
                                n_depth = 5'd1; n_mode = M_CMT;
                            end else begin
                                emit = 1'b1; n_tk = K_LPAR; n_mode = M_IDLE;
                                n_redo = 1'b1;
                            end
                        end
                        M_CMT, M_CSTAR, M_CPAREN: begin
                            if (r_mode == M_CSTAR && c == 8'h29) begin
                                n_depth = r_depth - 5'd1;
                                n_mode = (n_depth == '0) ? M_IDLE : M_CMT;
                            end else if (r_mode == M_CPAREN && c == 8'h2a) begin
                                if (r_depth >= 5'(MAX_COMMENT_NEST)) begin
                                    emit = 1'b1; n_tk = K_ERR; n_ec = E_NEST;
                                    n_tl = n_line; n_tcol = n_col; n_mode = M_HALT;
                                end else begin
                                    n_depth = r_depth + 5'd1; n_mode = M_CMT;
                                end
                            end else if (c == 8'h2a) n_mode = M_CSTAR;
                            else if (c == 8'h28) n_mode = M_CPAREN;
                            else n_mode = M_CMT;
                        end
                        default: ;
                    endcase

                    // Begin a token with this byte
                    if (start) begin
                        n_sl = n_line; n_sc = n_col; n_mode = M_IDLE;
                        n_tl = n_line; n_tcol = n_col;
                        if (is_space(c)) ;
                        else if (is_alpha(c)) begin
                            n_mode = M_IDENT; w_we = 1'b1; w_wa = '0; n_len = IW'(1);
                        end else if (is_digit(c)) begin
                            n_mode = M_NUM; n_num = {23'd0, c - 8'h30};
                        end else begin
                            emit = 1'b1;
                            unique case (c)
                                8'h22: begin emit = 1'b0; n_mode = M_STR; end
                                8'h3e: begin emit = 1'b0; n_mode = M_GT; end
                                8'h3c: begin emit = 1'b0; n_mode = M_LT; end
                                8'h2d: begin emit = 1'b0; n_mode = M_MINUS; end
                                8'h28: begin emit = 1'b0; n_mode = M_LPAR; end
                                8'h3d: n_tk = K_EQ;
                                8'h23: n_tk = K_NE;
                                8'h2b: n_tk = K_PLUS;
                                8'h2f: n_tk = K_DIV;
                                8'h2a: n_tk = K_MUL;
                                8'h26: n_tk = K_AMP;
                                8'h5b: n_tk = K_LBRACK;
                                8'h5d: n_tk = K_RBRACK;
                                8'h2c: n_tk = K_COMMA;
                                8'h29: n_tk = K_RPAR;
                                8'h3b: n_tk = K_SEMI;
                                default: begin
                                    n_tk = K_ERR; n_ec = E_ILLEGAL; n_mode = M_HALT;
                                end
                            endcase
                        end
                    end
                end
            end

            // Entering a run from the keyword search starts the read index at zero
            if (n_seq == S_RUN && r_seq == S_KW) n_ri = '0;
            if (emit) n_ov = 1'b1;
        end
    end

    assign o_valid        = r_ov;
    assign o_token_kind   = r_tk;
    assign o_number_value = r_nv;
    assign o_text_char    = r_tc;
    assign o_text_valid   = r_tv;
    assign o_token_line   = r_tl;
    assign o_token_column = r_tcol;
    assign o_error_code   = r_ec;
    assign o_last         = r_ol;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import stl_pkg::*;

    typedef struct packed {
        logic [5:0]  kind;
        logic [30:0] num;
        logic [7:0]  txt;
        logic        tv;
        logic [15:0] ln;
        logic [15:0] col;
        logic [3:0]  err;
        logic        last;
    } t_token;

    // Token predictor and store of expected tokens
    class lexer_scoreboard;
        t_mode       mode;
        logic [7:0]  ibuf [32];
        int          ilen;
        longint      acc;
        int          depth;
        int          line_no, col_no;
        bit          nl_seen;
        int          sline, scol;
        t_token      pending[$];
        int          errors;

        function void clear();
            mode = M_IDLE; ilen = 0; acc = 0; depth = 0;
            line_no = 1; col_no = 0; nl_seen = 0; sline = 1; scol = 0;
            pending.delete(); errors = 0;
        endfunction

        function void push(logic [5:0] k, longint n, logic [7:0] t, logic v,
                           int l, int c, logic [3:0] e, logic lst);
            t_token r;
            r.kind = k; r.num = n[30:0]; r.txt = t; r.tv = v;
            r.ln = l[15:0]; r.col = c[15:0]; r.err = e; r.last = lst;
            pending.push_back(r);
        endfunction

        function void single(logic [5:0] k);
            push(k, 0, 0, 0, sline, scol, E_NONE, 1);
        endfunction

        function void halt(logic [3:0] e, int l, int c);
            push(K_ERR, 0, 0, 0, l, c, e, 1);
            mode = M_HALT;
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction
        function bit digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        // Look the word up in the keyword list, else stream it out
        function void close_word();
            string words[23] = '{"and", "array", "begin", "boolean", "chill", "define",
                "do", "else", "elsif", "end", "exit", "false", "if", "integer", "mod",
                "not", "or", "program", "read", "then", "true", "while", "write"};
            bit hit;
            for (int k = 0; k < 23; k++) begin
                if (words[k].len() == ilen) begin
                    hit = 1;
                    for (int i = 0; i < ilen; i++)
                        if (words[k][i] != ibuf[i]) hit = 0;
                    if (hit) begin
                        single(k[5:0]);
                        return;
                    end
                end
            end
            for (int i = 0; i < ilen; i++)
                push(K_IDENT, 0, ibuf[i], 1, sline, scol, E_NONE, i + 1 == ilen);
        endfunction

        function void begin_token(logic [7:0] c);
            sline = line_no; scol = col_no; mode = M_IDLE;
            if (c == " " || (c >= 9 && c <= 13)) return;
            if (alpha(c)) begin
                mode = M_IDENT; ibuf[0] = c; ilen = 1; return;
            end
            if (digit(c)) begin
                mode = M_NUM; acc = c - "0"; return;
            end
            case (c)
                "\"": mode = M_STR;
                ">": mode = M_GT;
                "<": mode = M_LT;
                "-": mode = M_MINUS;
                "(": mode = M_LPAR;
                "=": single(K_EQ);
                "#": single(K_NE);
                "+": single(K_PLUS);
                "/": single(K_DIV);
                "*": single(K_MUL);
                "&": single(K_AMP);
                "[": single(K_LBRACK);
                "]": single(K_RBRACK);
                ",": single(K_COMMA);
                ")": single(K_RPAR);
                ";": single(K_SEMI);
                default: halt(E_ILLEGAL, line_no, col_no);
            endcase
        endfunction

        function void take_byte(logic [7:0] c);
            case (mode)
                M_IDLE: begin_token(c);
                M_IDENT: begin
                    if (alpha(c) || digit(c)) begin
                        if (ilen >= 32) halt(E_IDLONG, sline, scol);
                        else begin
                            ibuf[ilen] = c; ilen++;
                        end
                    end else begin
                        close_word(); begin_token(c);
                    end
                end
                M_NUM: begin
                    if (digit(c)) begin
                        if (acc > (64'd2147483647 - (c - "0")) / 10) halt(E_NUMBIG, sline, scol);
                        else acc = acc * 10 + (c - "0");
                    end else begin
                        push(K_NUM, acc, 0, 0, sline, scol, E_NONE, 1);
                        begin_token(c);
                    end
                end
                M_STR: begin
                    if (c == "\"") begin
                        push(K_STR, 0, 0, 0, sline, scol, E_NONE, 1); mode = M_IDLE;
                    end else if (c == "\\") mode = M_ESC;
                    else if (c >= 8'h20 && c <= 8'h7e) push(K_STR, 0, c, 1, sline, scol, E_NONE, 0);
                    else halt(E_NONPRT, line_no, col_no);
                end
                M_ESC: begin
                    if (c == "n" || c == "t" || c == "\"" || c == "\\") begin
                        push(K_STR, 0, "\\", 1, sline, scol, E_NONE, 0);
                        push(K_STR, 0, c, 1, sline, scol, E_NONE, 0);
                        mode = M_STR;
                    end else halt(E_ESCAPE, line_no, col_no);
                end
                M_GT: begin
                    if (c == "=") begin
                        single(K_GE); mode = M_IDLE;
                    end else begin
                        single(K_GT); begin_token(c);
                    end
                end
                M_LT: begin
                    if (c == "=") begin
                        single(K_LE); mode = M_IDLE;
                    end else if (c == "-") begin
                        single(K_GETS); mode = M_IDLE;
                    end else begin
                        single(K_LT); begin_token(c);
                    end
                end
                M_MINUS: begin
                    if (c == ">") begin
                        single(K_TO); mode = M_IDLE;
                    end else begin
                        single(K_MINUS); begin_token(c);
                    end
                end
                M_LPAR: begin
                    if (c == "*") begin
                        depth = 1; mode = M_CMT;
                    end else begin
                        single(K_LPAR); begin_token(c);
                    end
                end
                M_CMT, M_CSTAR, M_CPAREN: begin
                    if (mode == M_CSTAR && c == ")") begin
                        depth = (depth - 1) & 31;
                        mode = depth == 0 ? M_IDLE : M_CMT;
                    end else if (mode == M_CPAREN && c == "*") begin
                        if (depth >= 16) halt(E_NEST, line_no, col_no);
                        else begin
                            depth++; mode = M_CMT;
                        end
                    end else if (c == "*") mode = M_CSTAR;
                    else if (c == "(") mode = M_CPAREN;
                    else mode = M_CMT;
                end
                default: ;
            endcase
        endfunction

        // Note one accepted request and queue the tokens it yields
        function void note_request(logic kind, logic [7:0] c);
            if (kind) begin
                case (mode)
                    M_HALT: return;
                    M_IDENT: close_word();
                    M_NUM: push(K_NUM, acc, 0, 0, sline, scol, E_NONE, 1);
                    M_STR, M_ESC: begin
                        halt(E_STROPEN, sline, scol); return;
                    end
                    M_CMT, M_CSTAR, M_CPAREN: begin
                        halt(E_CMTOPEN, sline, scol); return;
                    end
                    M_GT: single(K_GT);
                    M_LT: single(K_LT);
                    M_MINUS: single(K_MINUS);
                    M_LPAR: single(K_LPAR);
                    default: ;
                endcase
                mode = M_IDLE;
                push(K_END, 0, 0, 0, line_no, col_no, E_NONE, 1);
                return;
            end
            if (mode == M_HALT) return;
            if (nl_seen) begin
                if (line_no < 65535) line_no++;
                col_no = 0;
            end
            if (col_no < 65535) col_no++;
            nl_seen = c == 8'd10;
            take_byte(c);
        endfunction

        function void check_token(t_token got);
            t_token want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind != want.kind) begin
                $display("%0t: token_kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.num != want.num) begin
                $display("%0t: number_value expected %0d actual %0d", $time, want.num, got.num);
                errors++;
            end
            if (got.txt != want.txt) begin
                $display("%0t: text_char expected %h actual %h", $time, want.txt, got.txt);
                errors++;
            end
            if (got.tv != want.tv) begin
                $display("%0t: text_valid expected %0d actual %0d", $time, want.tv, got.tv);
                errors++;
            end
            if (got.ln != want.ln) begin
                $display("%0t: token_line expected %0d actual %0d", $time, want.ln, got.ln);
                errors++;
            end
            if (got.col != want.col) begin
                $display("%0t: token_column expected %0d actual %0d", $time, want.col, got.col);
                errors++;
            end
            if (got.err != want.err) begin
                $display("%0t: error_code expected %0d actual %0d", $time, want.err, got.err);
                errors++;
            end
            if (got.last != want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic        i_kind = 0;
    logic [7:0]  i_char_code = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [5:0]  o_token_kind;
    logic [30:0] o_number_value;
    logic [7:0]  o_text_char;
    logic        o_text_valid;
    logic [15:0] o_token_line;
    logic [15:0] o_token_column;
    logic [3:0]  o_error_code;
    logic        o_last;

    source_text_lexer dut (.*);

    lexer_scoreboard sb = new();
    bit  quiet_tail = 0;
    bit  hold_off = 0;
    int  cycles = 0;
    localparam int CYCLE_LIMIT = 400000;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Check tokens and note requests on each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_request(i_kind, i_char_code);
            if (o_valid && i_ready)
                sb.check_token({o_token_kind, o_number_value, o_text_char, o_text_valid,
                                o_token_line, o_token_column, o_error_code, o_last});
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("source_text_lexer verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, a long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_ready <= 0;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 12);
                i_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    // Send one request and wait for it to be taken; valid stays up for the next one
    task automatic send(logic kind, logic [7:0] c);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_kind <= kind;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send(0, s[i]);
    endtask

    function automatic string pick_piece();
        string kw[8] = '{"begin", "while", "integer", "elsif", "program", "do", "x_1", "Abc"};
        string ops[12] = '{">=", "<=", "<-", "->", "=", "#", "+", "/", "*", "&", "[]", ",;)"};
        string s;
        int n;
        case ($urandom_range(0, 6))
            0: s = kw[$urandom_range(0, 7)];
            1: s = ops[$urandom_range(0, 11)];
            2: s = $sformatf("%0d", $urandom_range(0, 99999));
            3: begin
                s = "\"";
                n = $urandom_range(0, 4);
                repeat (n) s = $sformatf("%s%c", s, $urandom_range(48, 91));
                s = {s, "\\n\""};
            end
            4: s = "(* a (* b *) ( *)";
            5: s = "\n";
            default: s = "\t";
        endcase
        return {s, " "};
    endfunction

    initial begin
        int count;
        logic [7:0] c;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        sb.clear();
        @(posedge i_clk);

        // Directed: keywords, identifier, operators, numbers, strings, comments
        send_text("and chill if x_Z9 >= > <= <- < -> - ( );");
        send_text("2147483647 0 \"a\\t\\\"\\\\~ \" (*(*x*)*) (x\v\f\r\n");
        // Long receiver hold-off while a long identifier is streamed
        hold_off = 1;
        send_text("=#+/*&[],abcdefghijklmnopqrstuvwxyzABCDEF");
        send(1, 8'hff);

        // Random well-formed text
        count = 0;
        while (count < 16) begin
            string p;
            p = pick_piece();
            send_text(p);
            count += p.len();
            if (count > 6) quiet_tail = 1;
        end
        send(1, 0);

        // Close with an error: a random illegal byte, then a letter and an end mark while halted
        c = $urandom_range(0, 1) ? 8'h80 | 8'($urandom) : 8'h01;
        send(0, c);
        send(0, 8'h41);
        send(1, 0);
        i_valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) $display("source_text_lexer verification clean");
        else $display("source_text_lexer verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/stl_pkg.sv
src/stl_kwmatch.sv
src/source_text_lexer.sv
tb/sv/tb.sv
